// File: src/pslt_pkg.sv
package pslt_pkg;

    // Table size default
    localparam int NUM_AGENTS_DEF = 16;

    // Field widths
    localparam int ADDR_W = 32;
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int PCT_W  = 14;
    localparam int STAT_W = 2;

    // Loss percentage scale and divider sizing
    localparam logic [PCT_W-1:0] SCALE_HUNDREDTHS = PCT_W'(10000);
    localparam int NUM_W     = SEQ_W + PCT_W;
    localparam int DEN_W     = CNT_W + 1;
    localparam int DIV_CNT_W = $clog2(PCT_W);

    // Register reset
    localparam logic [TIME_W-1:0] INTERVAL_RST = TIME_W'(60);

    // Result status codes
    localparam logic [STAT_W-1:0] ST_COUNTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_LOSS    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ROLL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] source_addr;
        logic [SEQ_W-1:0]  record_seq;
        logic [TIME_W-1:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] agent_addr;
        logic [SEQ_W-1:0]  record_echo;
        logic [CNT_W-1:0]  received_count;
        logic [CNT_W-1:0]  lost_count;
        logic [PCT_W-1:0]  loss_hundredths;
    } t_out_item;

    // One table entry as stored in memory
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  packets;
        logic [SEQ_W-1:0]  last_seq;
        logic [TIME_W-1:0] window_start;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic idx_inc;
        logic load_hit;
        logic alloc;
        logic set_full;
        logic upd;
        logic decide;
        logic mul;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic at_end;
        logic full;
        logic hit;
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

// File: src/pslt_ifs.sv
interface pslt_in_if;
    logic               valid;
    logic               ready;
    pslt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pslt_out_if;
    logic                valid;
    logic                ready;
    pslt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pslt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pslt_pkg::TIME_W-1:0]      data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/pslt_ctrl.sv
module pslt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pslt_pkg::t_sts i_sts,
    output pslt_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MATCH  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequence one transaction through lookup, update and percentage
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.at_end) begin
                    if (i_sts.full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.alloc = 1'b1;
                        n_state     = S_UPDATE;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_MATCH;
                end
            end
            S_MATCH: begin
                if (i_sts.hit) begin
                    o_cmd.load_hit = 1'b1;
                    n_state        = S_UPDATE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SEARCH;
                end
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.need_div ? S_MUL : S_OUT;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until the sink takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/pslt_dp.sv
module pslt_dp #(
    parameter int NUM_AGENTS = pslt_pkg::NUM_AGENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pslt_pkg::t_in_item          i_in_data,
    input  logic                        i_cfg_valid,
    input  logic [pslt_pkg::TIME_W-1:0] i_cfg_data,
    input  pslt_pkg::t_cmd              i_cmd,
    output pslt_pkg::t_sts              o_sts,
    output pslt_pkg::t_out_item         o_out_data
);

    localparam int USED_W = $clog2(NUM_AGENTS + 1);
    localparam int IDX_W  = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
    localparam int CNT_W  = pslt_pkg::CNT_W;
    localparam int PCT_W  = pslt_pkg::PCT_W;
    localparam int DEN_W  = pslt_pkg::DEN_W;
    localparam int NUM_W  = pslt_pkg::NUM_W;
    localparam int DCW    = pslt_pkg::DIV_CNT_W;

    // Entry table, one write and one read port
    pslt_pkg::t_entry mem [NUM_AGENTS];

    logic [pslt_pkg::TIME_W-1:0] r_interval;
    logic [USED_W-1:0]           r_used;
    logic [USED_W-1:0]           r_idx;
    logic [IDX_W-1:0]            r_slot;
    pslt_pkg::t_in_item          r_in;
    pslt_pkg::t_entry            r_rd;
    pslt_pkg::t_entry            r_ent;
    logic [CNT_W-1:0]            r_pk;
    logic [pslt_pkg::TIME_W-1:0] r_elapsed;
    logic [pslt_pkg::SEQ_W-1:0]  r_expect;
    logic [pslt_pkg::SEQ_W-1:0]  r_d;
    logic [pslt_pkg::STAT_W-1:0] r_status;
    logic [CNT_W-1:0]            r_recv;
    logic [CNT_W-1:0]            r_lost;
    logic [DEN_W-1:0]            r_den;
    logic [DEN_W-1:0]            r_rem;
    logic [PCT_W-1:0]            r_low;
    logic [PCT_W-1:0]            r_q;
    logic [DCW-1:0]              r_div_cnt;
    pslt_pkg::t_out_item         r_out;

    logic                        due;
    logic                        in_order;
    logic [pslt_pkg::SEQ_W-1:0]  diff;
    logic                        need_div;
    pslt_pkg::t_entry            wr_entry;
    logic [NUM_W-1:0]            product;
    logic [DEN_W:0]              trial;
    logic                        take;

    // Window decision from registered update values
    assign due      = r_elapsed > r_interval;
    assign in_order = r_expect <= r_in.record_seq;
    assign diff     = r_in.record_seq - r_expect;
    assign need_div = due && in_order && (diff != '0) && (r_pk > CNT_W'(1));

    // Entry as it is written back: restarted window or bumped count
    always_comb begin
        wr_entry = r_ent;
        if (due) begin
            wr_entry.packets      = '0;
            wr_entry.last_seq     = r_in.record_seq;
            wr_entry.window_start = r_in.now_seconds;
        end else begin
            wr_entry.packets = r_pk;
        end
    end

    // Scaled loss and one restoring divide step
    assign product = NUM_W'(r_d) * NUM_W'(pslt_pkg::SCALE_HUNDREDTHS);
    assign trial   = {r_rem, r_low[PCT_W-1]};
    assign take    = trial >= {1'b0, r_den};

    assign o_sts.at_end   = (r_idx == r_used);
    assign o_sts.full     = (r_used == USED_W'(NUM_AGENTS));
    assign o_sts.hit      = (r_rd.addr == r_in.source_addr);
    assign o_sts.need_div = need_div;
    assign o_sts.div_last = (r_div_cnt == DCW'(PCT_W - 1));

    assign o_out_data = r_out;

    // Configuration register and table fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= pslt_pkg::INTERVAL_RST;
            r_used     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            if (i_cmd.alloc) begin
                r_used <= r_used + USED_W'(1);
            end
        end
    end

    // Table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= mem[r_idx[IDX_W-1:0]];
        end
        if (i_cmd.decide) begin
            mem[r_slot] <= wr_entry;
        end
    end

    // Lookup and entry update
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in  <= i_in_data;
            r_idx <= '0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + USED_W'(1);
        end
        if (i_cmd.load_hit) begin
            r_ent  <= r_rd;
            r_slot <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.alloc) begin
            r_ent.addr         <= r_in.source_addr;
            r_ent.packets      <= '0;
            r_ent.last_seq     <= '0;
            r_ent.window_start <= '0;
            r_slot             <= r_used[IDX_W-1:0];
        end
        if (i_cmd.upd) begin
            r_pk      <= r_ent.packets + CNT_W'(1);
            r_elapsed <= r_in.now_seconds - r_ent.window_start;
            r_expect  <= r_ent.last_seq + r_ent.packets + CNT_W'(1);
        end
    end

    // Result fields and percentage divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_full) begin
            r_status <= pslt_pkg::ST_FULL;
            r_recv   <= '0;
            r_lost   <= '0;
            r_q      <= '0;
        end
        if (i_cmd.decide) begin
            if (!due) begin
                r_status <= pslt_pkg::ST_COUNTED;
            end else if (in_order) begin
                r_status <= pslt_pkg::ST_LOSS;
            end else begin
                r_status <= pslt_pkg::ST_ROLL;
            end
            r_recv <= due ? r_pk : '0;
            r_lost <= need_div ? diff : '0;
            r_d    <= diff;
            r_q    <= '0;
        end
        if (i_cmd.mul) begin
            r_den     <= {1'b0, r_pk} + {1'b0, r_d};
            r_rem     <= DEN_W'(product[NUM_W-1:PCT_W]);
            r_low     <= product[PCT_W-1:0];
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= take ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_low     <= {r_low[PCT_W-2:0], 1'b0};
            r_q       <= {r_q[PCT_W-2:0], take};
            r_div_cnt <= r_div_cnt + DCW'(1);
        end
        if (i_cmd.out_load) begin
            r_out.status          <= r_status;
            r_out.agent_addr      <= r_in.source_addr;
            r_out.record_echo     <= r_in.record_seq;
            r_out.received_count  <= r_recv;
            r_out.lost_count      <= r_lost;
            r_out.loss_hundredths <= r_q;
        end
    end

endmodule

// File: src/per_source_sequence_loss_tracker_core.sv
// Per-source sequence loss tracker. Each input transaction names a source, its record
// sequence number and the current time; every input yields exactly one result. One
// transaction is in work at a time. The source is searched through the entry table one
// entry at a time (one memory read port, registered read data), reading an entry and
// then comparing its address; a loss percentage adds a multiply step and the 14-step
// restoring divider. A finished result waits in the output register while the next
// input is taken. report_interval may be written at any time the block is idle; the
// table needs no clearing after reset.
module per_source_sequence_loss_tracker_core #(
    parameter int NUM_AGENTS = pslt_pkg::NUM_AGENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pslt_in_if.sink           i_in,
    pslt_out_if.source        o_out,
    pslt_cfg_if.sink          i_cfg
);

    pslt_pkg::t_cmd cmd;
    pslt_pkg::t_sts sts;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    pslt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pslt_dp #(
        .NUM_AGENTS (NUM_AGENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out.data)
    );

endmodule

// File: src/pslt_checker.sv
module pslt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input pslt_pkg::t_out_item i_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed or dropped");

    // One transaction in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while busy");

    // Full table and plain count carry no window figures
    a_quiet_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == pslt_pkg::ST_FULL ||
                        i_out_data.status == pslt_pkg::ST_COUNTED)
        |-> i_out_data.received_count == '0 && i_out_data.lost_count == '0 &&
            i_out_data.loss_hundredths == '0)
        else $error("figures on a non-report result");

    // Percentage only with a loss, and never above all lost
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.loss_hundredths <= pslt_pkg::SCALE_HUNDREDTHS &&
            (i_out_data.lost_count != '0 || i_out_data.loss_hundredths == '0))
        else $error("loss percentage out of range");

endmodule

bind per_source_sequence_loss_tracker_core pslt_checker u_pslt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// File: tb/per_source_sequence_loss_tracker_core_tb.sv
module per_source_sequence_loss_tracker_core_tb;

    localparam int          AGENTS       = pslt_pkg::NUM_AGENTS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE_TICKS = 60;

    logic i_clk;
    logic i_rst_n;

    pslt_in_if  in_if ();
    pslt_out_if out_if ();
    pslt_cfg_if cfg_if ();

    per_source_sequence_loss_tracker_core #(.NUM_AGENTS(AGENTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the agent table and the interval register
    logic [pslt_pkg::TIME_W-1:0] interval_now;
    logic [pslt_pkg::ADDR_W-1:0] tbl_addr         [AGENTS];
    logic                        tbl_valid        [AGENTS];
    logic [pslt_pkg::CNT_W-1:0]  tbl_packets      [AGENTS];
    logic [pslt_pkg::SEQ_W-1:0]  tbl_last_seq     [AGENTS];
    logic [pslt_pkg::TIME_W-1:0] tbl_window_start [AGENTS];
    int                          tbl_used;

    // Reports still owed by the block, oldest first
    pslt_pkg::t_out_item pending_reports [$];

    // Traffic generator state: known sources, their next sequence, wall clock
    logic [pslt_pkg::ADDR_W-1:0] src_pool     [AGENTS];
    logic [pslt_pkg::SEQ_W-1:0]  src_next_seq [AGENTS];
    logic [pslt_pkg::TIME_W-1:0] clock_s;

    bit          gaps_on;
    bit          stall_on;
    int          mismatches = 0;
    int unsigned cycles     = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Compute the report for one accepted packet and advance the shadow table
    function automatic pslt_pkg::t_out_item predict_loss_report(
        input pslt_pkg::t_in_item pkt);
        pslt_pkg::t_out_item         rep;
        int                          slot;
        logic [pslt_pkg::CNT_W-1:0]  pk;
        logic [pslt_pkg::TIME_W-1:0] elapsed;
        logic [pslt_pkg::SEQ_W-1:0]  exp_seq;
        logic [pslt_pkg::SEQ_W-1:0]  gap;
        longint unsigned             num;
        longint unsigned             den;
        longint unsigned             scaled;
        rep             = '0;
        rep.status      = pslt_pkg::ST_COUNTED;
        rep.agent_addr  = pkt.source_addr;
        rep.record_echo = pkt.record_seq;
        slot            = -1;
        for (int i = 0; i < AGENTS; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_addr[i] == pkt.source_addr)
                slot = i;
        end
        // Claim the next free entry for a new source
        if (slot < 0 && tbl_used < AGENTS) begin
            slot                   = tbl_used;
            tbl_valid[slot]        = 1'b1;
            tbl_addr[slot]         = pkt.source_addr;
            tbl_packets[slot]      = '0;
            tbl_last_seq[slot]     = '0;
            tbl_window_start[slot] = '0;
            tbl_used++;
        end
        if (slot < 0) begin
            rep.status = pslt_pkg::ST_FULL;
        end else begin
            pk                = tbl_packets[slot] + 1;
            tbl_packets[slot] = pk;
            elapsed           = pkt.now_seconds - tbl_window_start[slot];
            // Close the window once the interval is strictly exceeded
            if (elapsed > interval_now) begin
                exp_seq            = tbl_last_seq[slot] + pk;
                rep.received_count = pk;
                if (exp_seq <= pkt.record_seq) begin
                    gap        = pkt.record_seq - exp_seq;
                    rep.status = pslt_pkg::ST_LOSS;
                    if (gap != 0 && pk > 1) begin
                        num                 = gap;
                        den                 = pk;
                        den                 = den + num;
                        scaled              = (num * pslt_pkg::SCALE_HUNDREDTHS) / den;
                        rep.lost_count      = gap;
                        rep.loss_hundredths = scaled[pslt_pkg::PCT_W-1:0];
                    end
                end else begin
                    rep.status = pslt_pkg::ST_ROLL;
                end
                tbl_window_start[slot] = pkt.now_seconds;
                tbl_last_seq[slot]     = pkt.record_seq;
                tbl_packets[slot]      = '0;
            end
        end
        return rep;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted report against the oldest pending one
    always @(posedge i_clk) begin
        pslt_pkg::t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual %p", $time,
                         out_if.data);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("status", want.status, out_if.data.status);
                check_field("agent_addr", want.agent_addr, out_if.data.agent_addr);
                check_field("record_echo", want.record_echo, out_if.data.record_echo);
                check_field("received_count", want.received_count,
                            out_if.data.received_count);
                check_field("lost_count", want.lost_count, out_if.data.lost_count);
                check_field("loss_hundredths", want.loss_hundredths,
                            out_if.data.loss_hundredths);
            end
        end
    end

    // Result side: stall ready in random bursts
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 9) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    // Send one packet transaction; valid stays high for a following packet
    task automatic send_item(input logic [pslt_pkg::ADDR_W-1:0] addr,
                             input logic [pslt_pkg::SEQ_W-1:0] seq,
                             input logic [pslt_pkg::TIME_W-1:0] now);
        pslt_pkg::t_in_item pkt;
        pkt.source_addr = addr;
        pkt.record_seq  = seq;
        pkt.now_seconds = now;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= pkt;
        do @(posedge i_clk); while (!in_if.ready);
        pending_reports.push_back(predict_loss_report(pkt));
    endtask

    // Hold off the sender until every pending report has arrived
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic write_interval(input logic [pslt_pkg::TIME_W-1:0] value);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        interval_now = value;
    endtask

    // Pick a known source and mostly advance its sequence in order
    task automatic send_stream_item(input int unsigned max_step);
        int                          k;
        int unsigned                 pick;
        logic [pslt_pkg::ADDR_W-1:0] addr;
        logic [pslt_pkg::SEQ_W-1:0]  seq;
        logic [pslt_pkg::TIME_W-1:0] now;
        k    = $urandom_range(0, AGENTS - 1);
        pick = $urandom_range(0, 99);
        addr = src_pool[k];
        if (pick < 72) begin
            seq             = src_next_seq[k];
            src_next_seq[k] = seq + 1;
        end else if (pick < 86) begin
            seq             = src_next_seq[k] + $urandom_range(1, 60);
            src_next_seq[k] = seq + 1;
        end else if (pick < 92) begin
            seq = src_next_seq[k] - $urandom_range(1, 20);
        end else if (pick < 96) begin
            seq             = $urandom;
            src_next_seq[k] = seq + 1;
        end else begin
            // Unknown source, rejected once the table is full
            addr = $urandom;
            seq  = $urandom;
        end
        // Advance the wall clock; now and then jump it or land near the wrap
        pick = $urandom_range(0, 199);
        if (pick == 0)
            clock_s = $urandom;
        else if (pick == 1)
            clock_s = 32'hFFFF_FFFF - $urandom_range(0, 100);
        else
            clock_s = clock_s + $urandom_range(0, max_step);
        now = clock_s;
        if ($urandom_range(0, 99) == 0)
            now = $urandom;
        send_item(addr, seq, now);
    endtask

    task automatic run_traffic(input int count, input int unsigned max_step,
                               input bit allow_idle);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                gaps_on  = allow_idle && $urandom_range(0, 3) != 0;
                stall_on = allow_idle && $urandom_range(0, 3) != 0;
            end
            if (allow_idle && $urandom_range(0, 249) == 0)
                drain_results();
            send_stream_item(max_step);
        end
    endtask

    // Window boundary, single packet, wrapped time and sequence, extreme loss
    task automatic test_window_basics();
        send_item(32'h0000_0000, 32'd0, 32'd0);
        send_item(32'h0000_0000, 32'd5, 32'd60);
        send_item(32'h0000_0000, 32'd9, 32'd61);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd1, 32'd60);
        send_item(32'h0000_0000, 32'd10, 32'd200);
        send_item(32'h0000_0000, 32'd3, 32'd400);
        send_item(32'h0000_0000, 32'd4, 32'd400);
        send_item(32'h0000_0000, 32'hFFFF_FFFF, 32'd1000);
    endtask

    task automatic test_out_of_order();
        send_item(32'h5A5A_5A5A, 32'd100, 32'd2000);
        send_item(32'h5A5A_5A5A, 32'd101, 32'd2001);
        send_item(32'h5A5A_5A5A, 32'd90, 32'd2100);
    endtask

    // Fill the remaining entries, then offer unknown sources
    task automatic test_table_full();
        for (int k = 3; k < AGENTS; k++)
            send_item(src_pool[k], $urandom, 32'd3000 + k);
        send_item(32'hA5A5_A5A5, 32'h8000_0000, 32'd3100);
        send_item($urandom, $urandom, $urandom);
    endtask

    task automatic test_interval_sweep();
        clock_s = 32'd5000;
        for (int k = 0; k < AGENTS; k++) begin
            if (k % 4 == 0)
                src_next_seq[k] = 32'hFFFF_FFFF - $urandom_range(0, 30);
            else
                src_next_seq[k] = $urandom;
        end
        run_traffic(400, 3, 1'b1);
        write_interval(32'd0);
        run_traffic(300, 3, 1'b1);
        write_interval(32'd7);
        run_traffic(400, 3, 1'b1);
        write_interval(32'hFFFF_FFFF);
        run_traffic(150, 3, 1'b1);
        write_interval(32'd1000);
        run_traffic(300, 80, 1'b1);
    endtask

    // Last stretch runs at full rate on both sides
    task automatic test_final_stretch();
        write_interval(32'd12);
        run_traffic(400, 3, 1'b0);
        gaps_on  = 1'b0;
        stall_on = 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        interval_now  = pslt_pkg::INTERVAL_RST;
        tbl_used      = 0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        for (int k = 0; k < AGENTS; k++) begin
            tbl_valid[k]    = 1'b0;
            src_next_seq[k] = '0;
        end
        // Known sources: the extremes, the directed one, then distinct random ones
        src_pool[0] = 32'h0000_0000;
        src_pool[1] = 32'hFFFF_FFFF;
        src_pool[2] = 32'h5A5A_5A5A;
        for (int k = 3; k < AGENTS; k++) begin
            bit clash;
            do begin
                src_pool[k] = $urandom;
                clash = (src_pool[k] == 32'hA5A5_A5A5);
                for (int j = 0; j < k; j++)
                    if (src_pool[j] == src_pool[k])
                        clash = 1'b1;
            end while (clash);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_window_basics();
        test_out_of_order();
        test_table_full();
        test_interval_sweep();
        test_final_stretch();

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: per_source_sequence_loss_tracker_core.f
src/pslt_pkg.sv
src/pslt_ifs.sv
src/pslt_ctrl.sv
src/pslt_dp.sv
src/per_source_sequence_loss_tracker_core.sv
src/pslt_checker.sv
tb/per_source_sequence_loss_tracker_core_tb.sv
